### sv/lu_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the LU linear solver: opcodes, status codes,
// controller states and the command and status groups between controller and datapath.
package lu_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] OP_WR_COEF = 2'd0;
  localparam logic [1:0] OP_WR_RHS  = 2'd1;
  localparam logic [1:0] OP_SOLVE   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SINGULAR  = 2'd1;
  localparam logic [1:0] STAT_SATURATED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_READ_WAIT, S_ELEM, S_MAC_RD, S_MUL, S_ACC, S_FIN_SUB,
    S_DIV_START, S_DIV_WAIT, S_WRITE, S_OUT_RD, S_OUT_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_FACT, PH_FWD, PH_BACK} phase_t;

  typedef enum logic [1:0] {EM_NONE, EM_READ, EM_SOLN, EM_SING} emit_t;

  typedef struct packed {
    logic  load_coef;
    logic  load_rhs;
    logic  rd_user;
    logic  rd_mac;
    logic  rd_fin;
    logic  rd_out;
    logic  clr_acc;
    logic  clr_sat;
    logic  mul;
    logic  acc;
    logic  fin_sub;
    logic  div_start;
    logic  wr;
    logic  use_div;
    emit_t emit;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic wr_zero;
  } dp_stat_t;

endpackage

### sv/lu_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider for the fixed-point quotient (num * 2^FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits. One quotient bit per cycle.
module lu_div #(
  parameter int FRAC_BITS = 16,
  localparam int NUM_W = 32 + FRAC_BITS,
  localparam int CW = $clog2(NUM_W + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic [31:0]        quot,
  output logic               sat
);

  logic [NUM_W-1:0] work;
  logic [31:0]      rem;
  logic [31:0]      dmag;
  logic             neg;
  logic             running;
  logic [CW-1:0]    cnt;

  logic [31:0] nmag;
  logic [32:0] rem_sh;
  logic        ge;
  logic        big;

  assign nmag   = num[31] ? (~num + 32'd1) : num;
  assign rem_sh = {rem, work[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NUM_W);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // The partial remainder stays below the divisor magnitude, so 32 bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= NUM_W'(nmag) << FRAC_BITS;
      rem  <= '0;
      dmag <= den[31] ? (~den + 32'd1) : den;
      neg  <= num[31] ^ den[31];
    end else if (running) begin
      rem  <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
      work <= {work[NUM_W-2:0], ge};
    end
  end

  assign big = |work[NUM_W-1:32];

  always_comb begin
    if (neg) begin
      sat  = big | (work[31] & (|work[30:0]));
      quot = sat ? 32'h8000_0000 : (~work[31:0] + 32'd1);
    end else begin
      sat  = big | work[31];
      quot = sat ? 32'h7FFF_FFFF : work[31:0];
    end
  end

endmodule

### sv/lu_dp.sv
`timescale 1ns / 1ps
// Datapath of the LU solver: coefficient, right-hand-side and vector memories,
// multiply-accumulate with saturation, divider and result registers. Uses lu_pkg, lu_div.
module lu_dp #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16,
  localparam int IW = $clog2(MAX_ORDER),
  localparam int AW = $clog2(MAX_ORDER * MAX_ORDER)
) (
  input  logic               clk,
  input  logic               rst,
  input  lu_pkg::dp_cmd_t    cmd,
  input  lu_pkg::phase_t     phase,
  input  logic [IW-1:0]      i_idx,
  input  logic [IW-1:0]      j_idx,
  input  logic [IW-1:0]      k_idx,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  output lu_pkg::dp_stat_t   stat,
  output logic               result_valid,
  output logic signed [31:0] result_value,
  output logic [3:0]         index,
  output logic [1:0]         status,
  output logic               last
);
  import lu_pkg::*;

  localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WMIN = 32'sh8000_0000;

  function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_ORDER) + AW'(c);
  endfunction

  logic signed [31:0] coef_mem [MAX_ORDER*MAX_ORDER];
  logic signed [31:0] rhs_mem  [MAX_ORDER];
  logic signed [31:0] vec_mem  [MAX_ORDER];

  logic signed [31:0] rd_a, rd_b, rd_r, rd_v;
  logic signed [63:0] prod;
  logic signed [31:0] acc, t_reg;
  logic               sat_flag;
  logic               user_oor;

  logic               in_rng, row_rng;
  logic [IW-1:0]      urow, ucol;
  logic [AW-1:0]      addr_a, addr_b, coef_waddr;
  logic [IW-1:0]      vec_addr;
  logic               coef_we;
  logic signed [31:0] coef_wdata, wr_data;

  logic signed [63:0] shifted;
  logic               mul_ovf, sum_ovf, dif_ovf;
  logic signed [31:0] mul_w, sum_w, dif_w, minuend, opb;
  logic signed [32:0] sum33, dif33;

  logic               div_done, div_sat;
  logic [31:0]        div_q;

  assign row_rng = 32'(row) < 32'(MAX_ORDER);
  assign in_rng  = row_rng && (32'(col) < 32'(MAX_ORDER));
  assign urow    = IW'(row);
  assign ucol    = IW'(col);

  always_comb begin
    if (cmd.rd_user) begin
      addr_a = mat_addr(urow, ucol);
    end else if (cmd.rd_fin) begin
      addr_a = mat_addr(i_idx, j_idx);
    end else begin
      addr_a = mat_addr(i_idx, k_idx);
    end
    if (cmd.rd_fin) begin
      addr_b = (phase == PH_FACT) ? mat_addr(j_idx, j_idx) : mat_addr(i_idx, i_idx);
    end else begin
      addr_b = mat_addr(k_idx, j_idx);
    end
    vec_addr = cmd.rd_mac ? k_idx : i_idx;
  end

  assign wr_data    = cmd.use_div ? $signed(div_q) : t_reg;
  assign coef_we    = (cmd.load_coef && in_rng) || (cmd.wr && phase == PH_FACT);
  assign coef_waddr = cmd.load_coef ? mat_addr(urow, ucol) : mat_addr(i_idx, j_idx);
  assign coef_wdata = cmd.load_coef ? value : wr_data;

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    if (cmd.rd_user || cmd.rd_mac || cmd.rd_fin) rd_a <= coef_mem[addr_a];
    if (cmd.rd_mac || cmd.rd_fin) rd_b <= coef_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rhs && row_rng) rhs_mem[urow] <= value;
    if (cmd.rd_fin) rd_r <= rhs_mem[i_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && phase != PH_FACT) vec_mem[i_idx] <= wr_data;
    if (cmd.rd_mac || cmd.rd_fin || cmd.rd_out) rd_v <= vec_mem[vec_addr];
  end

  // Product is floored by the arithmetic shift, then saturated before the add.
  assign opb     = (phase == PH_FACT) ? rd_b : rd_v;
  assign shifted = prod >>> FRAC_BITS;
  assign mul_ovf = !((&shifted[63:31]) || !(|shifted[63:31]));
  assign mul_w   = mul_ovf ? (shifted[63] ? WMIN : WMAX) : shifted[31:0];
  assign sum33   = {mul_w[31], mul_w} + {acc[31], acc};
  assign sum_ovf = sum33[32] != sum33[31];
  assign sum_w   = sum_ovf ? (sum33[32] ? WMIN : WMAX) : sum33[31:0];

  always_comb begin
    case (phase)
      PH_FACT: minuend = rd_a;
      PH_FWD:  minuend = rd_r;
      default: minuend = rd_v;
    endcase
  end

  assign dif33   = {minuend[31], minuend} - {acc[31], acc};
  assign dif_ovf = dif33[32] != dif33[31];
  assign dif_w   = dif_ovf ? (dif33[32] ? WMIN : WMAX) : dif33[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= rd_a * opb;
    if (cmd.clr_acc) begin
      acc <= '0;
    end else if (cmd.acc) begin
      acc <= sum_w;
    end
    if (cmd.fin_sub) t_reg <= dif_w;
    if (cmd.rd_user) user_oor <= !in_rng;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_sat) begin
      sat_flag <= 1'b0;
    end else if ((cmd.acc && (mul_ovf || sum_ovf)) || (cmd.fin_sub && dif_ovf) ||
                 (div_done && div_sat)) begin
      sat_flag <= 1'b1;
    end
  end

  lu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (t_reg),
    .den   (rd_b),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  assign stat.div_done = div_done;
  assign stat.wr_zero  = wr_data == 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit != EM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_READ: begin
        result_value <= user_oor ? 32'sd0 : rd_a;
        index        <= 4'd0;
        status       <= STAT_OK;
        last         <= 1'b1;
      end
      EM_SOLN: begin
        result_value <= rd_v;
        index        <= 4'(i_idx);
        status       <= sat_flag ? STAT_SATURATED : STAT_OK;
        last         <= cmd.last;
      end
      EM_SING: begin
        result_value <= 32'sd0;
        index        <= 4'(i_idx);
        status       <= STAT_SINGULAR;
        last         <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/lu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the LU solver: walks factoring, forward and back substitution and
// result output, issuing commands to lu_dp. Uses lu_pkg.
module lu_ctrl #(
  parameter int MAX_ORDER = 16,
  localparam int IW = $clog2(MAX_ORDER),
  localparam int NW = $clog2(MAX_ORDER + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       op,
  input  logic [NW-1:0]    n,
  input  lu_pkg::dp_stat_t stat,
  output logic             busy,
  output lu_pkg::dp_cmd_t  cmd,
  output lu_pkg::phase_t   phase,
  output logic [IW-1:0]    i_idx,
  output logic [IW-1:0]    j_idx,
  output logic [IW-1:0]    k_idx
);
  import lu_pkg::*;

  state_t        state, state_next;
  phase_t        phase_next;
  logic [IW-1:0] i, i_next, j, j_next, k, k_next;
  logic          piv_zero, piv_zero_next;

  logic [NW-1:0] nm1;
  logic          i_end, j_end, mac_more, need_div, zero_now;

  assign nm1      = n - NW'(1);
  assign i_end    = NW'(i) == nm1;
  assign j_end    = NW'(j) == nm1;
  assign need_div = (phase == PH_BACK) || (phase == PH_FACT && j < i);
  assign zero_now = (j == i) ? stat.wr_zero : piv_zero;

  always_comb begin
    case (phase)
      PH_FACT: mac_more = (k < i) && (k < j);
      PH_FWD:  mac_more = k < i;
      default: mac_more = k > i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_FACT;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      piv_zero <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      piv_zero <= piv_zero_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    piv_zero_next = piv_zero;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_SOLVE) begin
            phase_next = PH_FACT;
            i_next     = '0;
            j_next     = '0;
            state_next = S_ELEM;
          end else if (op == OP_READ) begin
            state_next = S_READ_WAIT;
          end
        end
      end
      S_READ_WAIT: state_next = S_IDLE;
      S_ELEM: begin
        k_next     = (phase == PH_BACK) ? IW'(nm1) : '0;
        state_next = S_MAC_RD;
      end
      S_MAC_RD: state_next = mac_more ? S_MUL : S_FIN_SUB;
      S_MUL:    state_next = S_ACC;
      S_ACC: begin
        k_next     = (phase == PH_BACK) ? k - IW'(1) : k + IW'(1);
        state_next = S_MAC_RD;
      end
      S_FIN_SUB:   state_next = need_div ? S_DIV_START : S_WRITE;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  state_next = stat.div_done ? S_WRITE : S_DIV_WAIT;
      S_WRITE: begin
        state_next = S_ELEM;
        case (phase)
          PH_FACT: begin
            if (j == i) piv_zero_next = stat.wr_zero;
            if (!j_end) begin
              j_next = j + IW'(1);
            end else if (zero_now) begin
              state_next = S_IDLE;
            end else if (!i_end) begin
              i_next = i + IW'(1);
              j_next = '0;
            end else begin
              phase_next = PH_FWD;
              i_next     = '0;
            end
          end
          PH_FWD: begin
            if (!i_end) begin
              i_next = i + IW'(1);
            end else begin
              phase_next = PH_BACK;
              i_next     = IW'(nm1);
            end
          end
          default: begin
            if (i != '0) begin
              i_next = i - IW'(1);
            end else begin
              state_next = S_OUT_RD;
            end
          end
        endcase
      end
      S_OUT_RD: state_next = S_OUT_EMIT;
      S_OUT_EMIT: begin
        if (i_end) begin
          state_next = S_IDLE;
        end else begin
          i_next     = i + IW'(1);
          state_next = S_OUT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = state != S_IDLE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_WR_COEF: cmd.load_coef = 1'b1;
            OP_WR_RHS:  cmd.load_rhs  = 1'b1;
            OP_READ:    cmd.rd_user   = 1'b1;
            default:    cmd.clr_sat   = 1'b1;
          endcase
        end
      end
      S_READ_WAIT: cmd.emit = EM_READ;
      S_ELEM:      cmd.clr_acc = 1'b1;
      S_MAC_RD: begin
        cmd.rd_mac = mac_more;
        cmd.rd_fin = !mac_more;
      end
      S_MUL:       cmd.mul = 1'b1;
      S_ACC:       cmd.acc = 1'b1;
      S_FIN_SUB:   cmd.fin_sub = 1'b1;
      S_DIV_START: cmd.div_start = 1'b1;
      S_WRITE: begin
        cmd.wr      = 1'b1;
        cmd.use_div = need_div;
        if (phase == PH_FACT && j_end && zero_now) cmd.emit = EM_SING;
      end
      S_OUT_RD:    cmd.rd_out = 1'b1;
      S_OUT_EMIT: begin
        cmd.emit = EM_SOLN;
        cmd.last = i_end;
      end
      default: begin
      end
    endcase
  end

  assign i_idx = i;
  assign j_idx = j;
  assign k_idx = k;

endmodule

### sv/lu_linear_solver_core.sv
`timescale 1ns / 1ps
// Coefficient and right-hand-side writes are taken one per clock with busy low.
// A read of a stored L/U entry holds busy during S_READ_WAIT; its result is strobed in the
// cycle after that. A solve runs on a single shared multiply-accumulate unit: each
// product term passes through S_MAC_RD, S_MUL and S_ACC; each computed element also
// passes S_ELEM, a final S_MAC_RD, S_FIN_SUB and S_WRITE, and every element that
// needs the bit-serial divider (each L entry and each back-substitution step) waits
// in S_DIV_START and S_DIV_WAIT before S_WRITE. Solution components then leave one
// at a time, each read in S_OUT_RD and emitted in S_OUT_EMIT.
// Results are strobed by result_valid for exactly one cycle and cannot be held off.
// Depends on lu_pkg, lu_ctrl, lu_dp, lu_div.
module lu_linear_solver_core #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  output logic               result_valid,
  output logic signed [31:0] result_value,
  output logic [3:0]         index,
  output logic [1:0]         status,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lu_pkg::*;

  localparam int IW = $clog2(MAX_ORDER);
  localparam int NW = $clog2(MAX_ORDER + 1);

  logic [4:0]    size_used;
  logic [NW-1:0] n_eff;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  phase_t        phase;
  logic [IW-1:0] i_idx, j_idx, k_idx;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, size_used};

  always_ff @(posedge clk) begin
    if (rst) begin
      size_used <= 5'd16;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      size_used <= pwdata[4:0];
    end
  end

  // Order zero behaves as one; orders beyond the storage are clamped.
  always_comb begin
    if (size_used == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(size_used) > 32'(MAX_ORDER)) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(size_used);
    end
  end

  lu_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .n     (n_eff),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd),
    .phase (phase),
    .i_idx (i_idx),
    .j_idx (j_idx),
    .k_idx (k_idx)
  );

  lu_dp #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .phase        (phase),
    .i_idx        (i_idx),
    .j_idx        (j_idx),
    .k_idx        (k_idx),
    .row          (row),
    .col          (col),
    .value        (value),
    .stat         (stat),
    .result_valid (result_valid),
    .result_value (result_value),
    .index        (index),
    .status       (status),
    .last         (last)
  );

endmodule

### bench/lu_linear_solver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lu_linear_solver_core: loads, solves and reads
// checked against an in-bench fixed-point LU predictor. Depends on lu_pkg.
module lu_linear_solver_core_tb;
  import lu_pkg::*;

  localparam int ORDER_MAX = 16;
  localparam int CYCLE_LIMIT = 900000;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t          kind;
    logic [1:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } act_t;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic [1:0]         status;
    logic               last;
  } soln_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_WR_COEF;
  logic [3:0] row = '0;
  logic [3:0] col = '0;
  logic signed [31:0] value = '0;
  logic result_valid;
  logic signed [31:0] result_value;
  logic [3:0] index;
  logic [1:0] status;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b1;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lu_linear_solver_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .row(row), .col(col),
    .value(value), .result_valid(result_valid), .result_value(result_value),
    .index(index), .status(status), .last(last), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  act_t  act_q[$];
  soln_t soln_q[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_solves = 0;
  int    n_results = 0;
  int    n_sizes = 0;

  // Predictor state.
  logic signed [31:0] lu_mem [ORDER_MAX*ORDER_MAX];
  logic signed [31:0] rhs_mem [ORDER_MAX];
  bit                 sat_seen;
  logic [4:0]         order_reg = 5'd16;

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
    return clip((longint'(a) <<< 16) / longint'(b));
  endfunction

  task automatic predict_solve();
    int n, lim;
    logic signed [31:0] s, y[ORDER_MAX], x[ORDER_MAX];
    soln_t r;
    n = (order_reg == 0) ? 1 : ((order_reg > ORDER_MAX) ? ORDER_MAX : int'(order_reg));
    sat_seen = 1'b0;
    n_solves++;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        s = 0;
        lim = (j < i) ? j : i;
        for (int k = 0; k < lim; k++)
          s = clip(longint'(s) + fx_mul(lu_mem[i*ORDER_MAX+k], lu_mem[k*ORDER_MAX+j]));
        s = clip(longint'(lu_mem[i*ORDER_MAX+j]) - longint'(s));
        lu_mem[i*ORDER_MAX+j] = (j < i) ? fx_div(s, lu_mem[j*ORDER_MAX+j]) : s;
      end
      if (lu_mem[i*ORDER_MAX+i] == 0) begin
        r = '{0, i[3:0], STAT_SINGULAR, 1'b1};
        soln_q.push_back(r);
        return;
      end
    end
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int k = 0; k < i; k++)
        s = clip(longint'(s) + fx_mul(lu_mem[i*ORDER_MAX+k], y[k]));
      y[i] = clip(longint'(rhs_mem[i]) - longint'(s));
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int k = n - 1; k > i; k--)
        s = clip(longint'(s) + fx_mul(lu_mem[i*ORDER_MAX+k], x[k]));
      x[i] = fx_div(clip(longint'(y[i]) - longint'(s)), lu_mem[i*ORDER_MAX+i]);
    end
    for (int i = 0; i < n; i++) begin
      r = '{x[i], i[3:0], sat_seen ? STAT_SATURATED : STAT_OK, i == n - 1};
      soln_q.push_back(r);
    end
  endtask

  task automatic predict_item(logic [1:0] o, logic [3:0] r, logic [3:0] c,
                              logic signed [31:0] v);
    soln_t e;
    n_items++;
    case (o)
      OP_WR_COEF: lu_mem[r*ORDER_MAX+c] = v;
      OP_WR_RHS:  rhs_mem[r] = v;
      OP_SOLVE:   predict_solve();
      default: begin
        e = '{lu_mem[r*ORDER_MAX+c], 4'd0, STAT_OK, 1'b1};
        soln_q.push_back(e);
      end
    endcase
  endtask

  // Stimulus building; tracks which entries were written so reads stay legal.
  bit coef_wr [ORDER_MAX*ORDER_MAX];
  bit rhs_wr [ORDER_MAX];
  int queued_items = 0;

  task automatic add_item(logic [1:0] o, int r, int c, logic signed [31:0] v);
    act_t a;
    a = '{ACT_ITEM, o, r[3:0], c[3:0], v};
    act_q.push_back(a);
    queued_items++;
    if (o == OP_WR_COEF) coef_wr[r*ORDER_MAX+c] = 1'b1;
    if (o == OP_WR_RHS) rhs_wr[r] = 1'b1;
  endtask

  task automatic add_ctl(act_kind_t k, logic signed [31:0] v);
    act_t a;
    a = '{k, OP_WR_COEF, 4'd0, 4'd0, v};
    act_q.push_back(a);
  endtask

  function automatic logic signed [31:0] rand_entry(bit diag, int n);
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return $urandom;
    if (m == 1) return 0;
    if (diag)
      return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(n << 16, (3 * n + 2) << 16));
    return int'($urandom_range(0, 1 << 18)) - (1 << 17);
  endfunction

  task automatic random_phase(int n, int cfg_value);
    int r, c;
    add_ctl(ACT_CFG, cfg_value);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        add_item(OP_WR_COEF, i, j, rand_entry(i == j, n));
    for (int i = 0; i < n; i++)
      add_item(OP_WR_RHS, i, $urandom_range(0, 15), rand_entry(0, n) <<< 2);
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 3) == 0)
        add_item(OP_WR_COEF, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                 rand_entry(0, n));
      add_item(OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      repeat ($urandom_range(0, 3)) begin
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
        if (!coef_wr[r*ORDER_MAX+c]) begin
          r = $urandom_range(0, n - 1);
          c = $urandom_range(0, n - 1);
        end
        add_item(OP_READ, r, c, $urandom);
      end
    end
    if ($urandom_range(0, 2) == 0) add_ctl(ACT_DRAIN, 0);
  endtask

  // Driver.
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_cnt = 0;
  int   apb_step = 0;

  always @(posedge clk) begin
    logic nstart, npsel, npen;
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
    end else begin
      nstart = start;
      npsel = psel;
      npen = penable;
      if (start && !busy) begin
        predict_item(op, row, col, value);
        nstart = 1'b0;
      end
      if (apb_step == 1) begin
        npen = 1'b1;
        apb_step = 2;
      end else if (apb_step == 2) begin
        order_reg = pwdata[4:0];
        npsel = 1'b0;
        npen = 1'b0;
        apb_step = 0;
      end else if (!nstart && act_q.size() > 0) begin
        if (act_q[0].kind == ACT_ITEM) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            nstart = 1'b1;
            op <= act_q[0].op;
            row <= act_q[0].row;
            col <= act_q[0].col;
            value <= act_q[0].value;
            void'(act_q.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 12);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end else if (soln_q.size() != 0 || busy) begin
          hold_cnt = 0;
        end else if (hold_cnt < 8) begin
          hold_cnt++;
        end else begin
          // The block is idle: safe to change the order of the system.
          hold_cnt = 0;
          if (act_q[0].kind == ACT_CFG) begin
            npsel = 1'b1;
            paddr <= 3'd0;
            pwdata <= act_q[0].value;
            apb_step = 1;
            n_sizes++;
          end
          void'(act_q.pop_front());
        end
      end
      start <= nstart;
      psel <= npsel;
      penable <= npen;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    soln_t e;
    if (!rst && result_valid) begin
      n_results++;
      if (soln_q.size() == 0) begin
        $error("unexpected result value=%0d index=%0d", result_value, index);
        errors++;
      end else begin
        e = soln_q.pop_front();
        if (result_value !== e.value) begin
          $error("result_value expected %0d got %0d", e.value, result_value);
          errors++;
        end
        if (index !== e.index) begin
          $error("index expected %0d got %0d", e.index, index);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d got %0d", e.status, status);
          errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d got %0d", e.last, last);
          errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (lu_mem[i]) lu_mem[i] = 0;
    foreach (rhs_mem[i]) rhs_mem[i] = 0;

    // Directed: word extremes, saturation, zero pivots in first and final row.
    add_ctl(ACT_CFG, 0);
    add_item(OP_WR_COEF, 0, 0, 32'sh7fffffff);
    add_item(OP_READ, 0, 0, 0);
    add_item(OP_WR_COEF, 0, 0, 32'sh80000000);
    add_item(OP_READ, 0, 0, 0);
    add_item(OP_WR_COEF, 0, 0, 1);
    add_item(OP_WR_RHS, 0, 15, 32'sh7fffffff);
    add_item(OP_SOLVE, 0, 0, 0);
    add_item(OP_WR_COEF, 0, 0, 0);
    add_item(OP_SOLVE, 15, 15, -1);
    add_ctl(ACT_CFG, 2);
    add_item(OP_WR_COEF, 0, 0, 1 << 16);
    add_item(OP_WR_COEF, 0, 1, 1 << 16);
    add_item(OP_WR_COEF, 1, 0, 1 << 16);
    add_item(OP_WR_COEF, 1, 1, 1 << 16);
    add_item(OP_WR_RHS, 0, 0, 3 << 16);
    add_item(OP_WR_RHS, 1, 0, -(5 << 16));
    add_item(OP_SOLVE, 0, 0, 0);
    add_item(OP_READ, 1, 1, 0);
    add_item(OP_WR_COEF, 0, 0, 2 << 16);
    add_item(OP_WR_COEF, 1, 1, 3 << 16);
    add_item(OP_SOLVE, 0, 0, 0);
    add_item(OP_SOLVE, 0, 0, 0);
    add_item(OP_READ, 1, 0, 0);
    add_ctl(ACT_DRAIN, 0);

    while (queued_items < 190) begin
      int n;
      n = $urandom_range(1, 5);
      random_phase(n, (n == 1 && $urandom_range(0, 1)) ? 0 : n);
    end

    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (act_q.size() == 0 && !start && apb_step == 0);
    wait (soln_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("Ran %0d transactions, %0d solves and %0d size settings; %0d results checked.",
             n_items, n_solves, n_sizes, n_results);
    if (errors == 0 && soln_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
